// File: design/mdcs_pkg.sv
// Package for the most-divisors range search.
// Holds default widths, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package mdcs_pkg;

  localparam int VALUE_BITS_DEF = 20;
  localparam int COUNT_BITS_DEF = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CAND,
    S_TEST,
    S_WAIT,
    S_COMMIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_range;
    logic cand_init;
    logic trial_start;
    logic trial_update;
    logic cand_commit;
    logic cand_next;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic div_zero;
    logic cand_is_last;
    logic rem_done;
  } status_t;

endpackage

`default_nettype wire

// File: design/mdcs_rem.sv
// Iterative remainder unit: restoring division, one quotient bit per cycle.
// Depends on mdcs_pkg; used by mdcs_dp.
`default_nettype none

module mdcs_rem #(
  parameter int VALUE_BITS = mdcs_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output logic                       busy,
  output logic                       done,
  output logic                       rem_zero
);

  localparam int BW = $clog2(VALUE_BITS);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic [VALUE_BITS-1:0] shf_r, shf_nxt;
  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  assign trial = {rem_r, shf_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    bit_nxt  = bit_r;
    shf_nxt  = shf_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      bit_nxt  = '0;
      shf_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      shf_nxt = {shf_r[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[VALUE_BITS-1:0];
      end else begin
        rem_nxt = trial[VALUE_BITS-1:0];
      end
      bit_nxt = bit_r + 1'b1;
      if (bit_r == BW'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
    shf_r <= shf_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

`default_nettype wire

// File: design/mdcs_dp.sv
// Datapath: range, candidate, trial divisor, counts, best and output registers.
// Depends on mdcs_pkg and mdcs_rem.
`default_nettype none

module mdcs_dp #(
  parameter int VALUE_BITS = mdcs_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = mdcs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mdcs_pkg::cmd_t        cmd,
  output mdcs_pkg::status_t          status,
  input  wire logic [VALUE_BITS-1:0] range_first,
  input  wire logic [VALUE_BITS-1:0] range_last,
  output logic      [VALUE_BITS-1:0] best_value,
  output logic      [COUNT_BITS-1:0] best_count
);

  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic [VALUE_BITS-1:0] last_r, last_nxt;
  logic [VALUE_BITS-1:0] div_r, div_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] bval_r, bval_nxt;
  logic [COUNT_BITS-1:0] bcnt_r, bcnt_nxt;
  logic [VALUE_BITS-1:0] oval_r, oval_nxt;
  logic [COUNT_BITS-1:0] ocnt_r, ocnt_nxt;
  logic                  rem_busy;
  logic                  rem_done;
  logic                  rem_zero;

  mdcs_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.trial_start),
    .dividend (cand_r),
    .divisor  (div_r),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    cand_nxt = cand_r;
    last_nxt = last_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    bval_nxt = bval_r;
    bcnt_nxt = bcnt_r;
    oval_nxt = oval_r;
    ocnt_nxt = ocnt_r;
    if (cmd.load_range) begin
      cand_nxt = range_first;
      last_nxt = range_last;
      bval_nxt = '0;
      bcnt_nxt = '0;
    end
    if (cmd.cand_init) begin
      div_nxt = cand_r >> 1;
      cnt_nxt = '0;
    end
    if (cmd.trial_update) begin
      div_nxt = div_r - 1'b1;
      if (rem_zero && (cnt_r != '1)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (cmd.cand_commit && (cnt_r > bcnt_r)) begin
      bval_nxt = cand_r;
      bcnt_nxt = cnt_r;
    end
    if (cmd.cand_next) begin
      cand_nxt = cand_r + 1'b1;
    end
    if (cmd.load_out) begin
      oval_nxt = bval_r;
      ocnt_nxt = bcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
      div_r  <= '0;
      cnt_r  <= '0;
      bval_r <= '0;
      bcnt_r <= '0;
    end else begin
      cand_r <= cand_nxt;
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
      bval_r <= bval_nxt;
      bcnt_r <= bcnt_nxt;
    end
    last_r <= last_nxt;
    oval_r <= oval_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign status.range_empty  = (last_r < cand_r);
  assign status.div_zero     = (div_r == '0);
  assign status.cand_is_last = (cand_r == last_r);
  assign status.rem_done     = rem_done;

  assign best_value = oval_r;
  assign best_count = ocnt_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trial_start |-> !rem_busy && !rem_done)
    else $error("remainder unit started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> $past(rem_busy))
    else $error("remainder done without a running division");

  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cand_next |-> cand_r != last_r)
    else $error("candidate advanced past the end of the range");

  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_range |=> bcnt_r == '0 && bval_r == '0)
    else $error("best not cleared at start of search");
`endif

endmodule

`default_nettype wire

// File: design/mdcs_ctrl.sv
// Controller state machine for the search; sequences the datapath.
// Depends on mdcs_pkg.
`default_nettype none

module mdcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire mdcs_pkg::status_t  status,
  output mdcs_pkg::cmd_t          cmd
);

  mdcs_pkg::state_t state_r, state_nxt;
  logic             ovld_r, ovld_nxt;
  logic             out_free;

  assign out_free = !ovld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mdcs_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mdcs_pkg::S_CHECK;
      end
      mdcs_pkg::S_CHECK: begin
        state_nxt = status.range_empty ? mdcs_pkg::S_FINISH : mdcs_pkg::S_CAND;
      end
      mdcs_pkg::S_CAND: begin
        state_nxt = mdcs_pkg::S_TEST;
      end
      mdcs_pkg::S_TEST: begin
        state_nxt = status.div_zero ? mdcs_pkg::S_COMMIT : mdcs_pkg::S_WAIT;
      end
      mdcs_pkg::S_WAIT: begin
        if (status.rem_done) state_nxt = mdcs_pkg::S_TEST;
      end
      mdcs_pkg::S_COMMIT: begin
        state_nxt = status.cand_is_last ? mdcs_pkg::S_FINISH : mdcs_pkg::S_CAND;
      end
      mdcs_pkg::S_FINISH: begin
        if (out_free) state_nxt = mdcs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mdcs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      mdcs_pkg::S_IDLE: begin
        in_tready      = 1'b1;
        cmd.load_range = in_tvalid;
      end
      mdcs_pkg::S_CAND: begin
        cmd.cand_init = 1'b1;
      end
      mdcs_pkg::S_TEST: begin
        cmd.trial_start = !status.div_zero;
      end
      mdcs_pkg::S_WAIT: begin
        cmd.trial_update = status.rem_done;
      end
      mdcs_pkg::S_COMMIT: begin
        cmd.cand_commit = 1'b1;
        cmd.cand_next   = !status.cand_is_last;
      end
      mdcs_pkg::S_FINISH: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.load_out) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdcs_pkg::S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;

`ifndef ASSERT_OFF
  a_wait_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trial_start |=> state_r == mdcs_pkg::S_WAIT)
    else $error("division started without waiting for it");

  a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !ovld_r || out_tready)
    else $error("output overwritten before it was taken");

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_range |=> state_r == mdcs_pkg::S_CHECK)
    else $error("accepted word not checked");
`endif

endmodule

`default_nettype wire

// File: design/max_divisor_count_search.sv
// Top level of the most-divisors range search by trial division.
// Depends on mdcs_pkg, mdcs_ctrl, mdcs_dp, mdcs_rem.
//
// Channel  Dir  Ports                     Word
// in       in   in_tvalid/tready/tdata    range_first, range_last
// out      out  out_tvalid/tready/tdata   best_value, best_count
//
// Each trial divisor is checked in the bit-serial remainder unit.
// A value v is tried with each divisor from floor(v/2) down to 1.
// Reset is synchronous, active low; no clearing pass.
// A new word is taken while the previous result waits in the output register;
// the search holds in its final state until that register is free.
`default_nettype none

module max_divisor_count_search #(
  parameter int VALUE_BITS = mdcs_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = mdcs_pkg::COUNT_BITS_DEF,
  localparam int IN_W  = ((2 * VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // range_first, range_last
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // best_value, best_count
  output logic      [OUT_W-1:0] out_tdata
);

  mdcs_pkg::cmd_t        cmd;
  mdcs_pkg::status_t     status;
  logic [VALUE_BITS-1:0] best_value;
  logic [COUNT_BITS-1:0] best_count;

  mdcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mdcs_dp #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .range_first (in_tdata[VALUE_BITS-1:0]),
    .range_last  (in_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .best_value  (best_value),
    .best_count  (best_count)
  );

  assign out_tdata = OUT_W'({best_count, best_value});

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for max_divisor_count_search.
// Feeds ranges through the input stream under several pacing phases and checks
// each returned word against a trial-division search. Depends on mdcs_pkg.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS = mdcs_pkg::VALUE_BITS_DEF;
  localparam int COUNT_BITS = mdcs_pkg::COUNT_BITS_DEF;
  localparam int IN_W = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int VALUE_MAX = (1 << VALUE_BITS) - 1;
  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int STALL_LIMIT = 250000;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    value_t best_value;
    count_t best_count;
  } best_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [IN_W-1:0] pending_ranges[$];
  best_t expected_best[$];
  logic in_fire = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int ranges_taken = 0;
  int empty_ranges = 0;
  int results_checked = 0;
  int idle_cycles = 0;

  max_divisor_count_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // range_first, range_last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // best_value, best_count
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic count_t count_proper_divisors(int unsigned v);
    int unsigned n;
    n = 0;
    for (int unsigned d = 1; d <= v / 2; d++) begin
      if (v % d == 0) n++;
    end
    if (n > COUNT_MAX) n = COUNT_MAX;
    return count_t'(n);
  endfunction

  function automatic best_t search_best(value_t first, value_t last);
    best_t best;
    count_t c;
    best = '0;
    if (last >= first) begin
      for (int unsigned v = first; v <= last; v++) begin
        c = count_proper_divisors(v);
        if (c > best.best_count) begin
          best.best_count = c;
          best.best_value = value_t'(v);
        end
      end
    end
    return best;
  endfunction

  task automatic add_range(int unsigned first, int unsigned last);
    pending_ranges.push_back({value_t'(last), value_t'(first)});
  endtask

  task automatic add_random_range();
    int unsigned first;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 78) begin
      first = $urandom_range(120, 0);
      add_range(first, first + $urandom_range(12, 0));
    end else if (pick < 88) begin
      first = $urandom_range(600, 200);
      add_range(first, first + $urandom_range(2, 0));
    end else if (pick < 94) begin
      first = $urandom_range(VALUE_MAX, 1);
      add_range(first, $urandom_range(first - 1, 0));
    end else begin
      first = $urandom_range(VALUE_MAX, 1);
      add_range(first, first - 1);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int items);
    @(posedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) add_random_range();
    while (pending_ranges.size() != 0 || in_tvalid || expected_best.size() != 0)
      @(posedge clk);
  endtask

  // drive the input stream
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (pending_ranges.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
      in_tdata <= pending_ranges.pop_front();
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // check results, then predict for the accepted range
  always @(posedge clk) begin
    best_t want;
    value_t got_value;
    count_t got_count;
    value_t first;
    value_t last;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      got_value = out_tdata[VALUE_BITS-1:0];
      got_count = out_tdata[VALUE_BITS+COUNT_BITS-1:VALUE_BITS];
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (expected_best.size() == 0) begin
          $error("result with nothing pending: best_value %0d best_count %0d",
                 got_value, got_count);
          error_count++;
        end else begin
          want = expected_best.pop_front();
          if (got_value !== want.best_value) begin
            $error("best_value expected %0d actual %0d", want.best_value, got_value);
            error_count++;
          end
          if (got_count !== want.best_count) begin
            $error("best_count expected %0d actual %0d", want.best_count, got_count);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        first = in_tdata[VALUE_BITS-1:0];
        last = in_tdata[2*VALUE_BITS-1:VALUE_BITS];
        expected_best.push_back(search_best(first, last));
        ranges_taken++;
        if (last < first) empty_ranges++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    add_range(0, 0);
    add_range(1, 1);
    add_range(0, 1);
    add_range(2, 2);
    add_range(13, 13);
    add_range(12, 12);
    add_range(6, 11);
    add_range(8, 10);
    add_range(5, 3);
    add_range(VALUE_MAX, 0);
    add_range(VALUE_MAX, VALUE_MAX - 1);
    add_range(VALUE_MAX, VALUE_MAX - 2);
    add_range(1 << (VALUE_BITS - 1), (1 << (VALUE_BITS - 1)) - 1);
    add_range(20'hAAAAA, 20'h55555);
    add_range(20'h55555, 20'h2AAAA);
    add_range(0, 60);
    add_range(0, 30);
    add_range(360, 365);
    add_range(5040, 5040);
    add_range(1, 0);
    run_phase(0, 0, 25);
    run_phase(84, 0, 25);
    run_phase(0, 84, 25);
    run_phase(27, 27, 25);

    repeat (50) @(posedge clk);
    $display("Searched %0d ranges (%0d empty), checked %0d results", ranges_taken,
             empty_ranges, results_checked);
    $display("Pacing phases: free running, sender gaps, receiver stalls, both mixed");
    if (error_count == 0 && expected_best.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: max_divisor_count_search.f
design/mdcs_pkg.sv
design/mdcs_rem.sv
design/mdcs_dp.sv
design/mdcs_ctrl.sv
design/max_divisor_count_search.sv
test/testbench.sv
